// ----- rtl/ncge_pkg.sv -----
// Shared types and constants of the n-point correlator group evaluator.
package ncge_pkg;

  // Input word kinds, carried on the slave-side tuser.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Result status codes, carried on the master-side tuser.
  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_OOR  = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_POINT_COUNT    = 2'd0;
  localparam logic [1:0] REG_PARTICLE_COUNT = 2'd1;
  localparam logic [1:0] REG_WEIGHT_POWER   = 2'd2;
  localparam logic [1:0] REG_INV_SCALE      = 2'd3;

  // Field widths.
  localparam int PT_W    = 16;
  localparam int ETA_W   = 16;
  localparam int PHI_W   = 15;
  localparam int ENTRY_W = PT_W + ETA_W + PHI_W;
  localparam int GROUP_W = 30;
  localparam int DIST_W  = 17;

  // Arithmetic unit widths.
  localparam int MUL_W  = 64;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 34;

  // Angle constants in Q3.12.
  localparam logic signed [16:0] PI_Q12     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12 = 17'sd25736;

  // 1.0 in Q32.32.
  localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

endpackage

// ----- rtl/npoint_correlator_group_eval.sv -----
// Top level of the n-point correlator group evaluator: sequencer, store and result register.
//
//  Channel  | Direction | Handshake                    | Content
//  ---------+-----------+------------------------------+---------------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | load or query word, kind on tuser
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | result word, status on tuser
//  cfg      | in        | cfg_valid_i/cfg_ready_o      | register index and write data
//
// A query word is worked through by a sequencer that drives one shared 64x64
// multiplier (four 32x32 partial products) and one bit-serial square root unit.
// A query forms the group powers, then the digits, the weight, the extra power
// steps and the member pairs; a group out of range ends after the group powers.
// Reset is asynchronous and active low; the particle store is not cleared.
// The input is taken only while the sequencer is idle; a finished result waits in the
// output register and the next word can be taken while it is still held there.
module npoint_correlator_group_eval import ncge_pkg::*; #(
  parameter int MAX_PARTICLES = 64,
  parameter int MAX_POINTS    = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: slot[5:0], pt[21:6], eta[37:22], phi[52:38], group[82:53], zero fill [87:83]
  input  logic [87:0] s_axis_tdata,
  // tuser: kind[0]
  input  logic        s_axis_tuser,
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: weight[63:0], distance[80:64], first_member[86:81], second_member[92:87],
  //        zero fill [95:93]
  output logic [95:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int QW   = $clog2(MAX_PARTICLES);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int PWW  = QW * MAX_POINTS + 1;
  localparam int TW   = PWW + QW;
  localparam int CMPW = (TW > GROUP_W) ? TW : GROUP_W;
  localparam int DCW  = $clog2(QW + 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_POW_GO   = 5'd1;
  localparam logic [4:0] S_POW_WAIT = 5'd2;
  localparam logic [4:0] S_RANGE    = 5'd3;
  localparam logic [4:0] S_DIG      = 5'd4;
  localparam logic [4:0] S_W_RD     = 5'd5;
  localparam logic [4:0] S_W_GO     = 5'd6;
  localparam logic [4:0] S_W_WAIT   = 5'd7;
  localparam logic [4:0] S_P_INIT   = 5'd8;
  localparam logic [4:0] S_P_CHK    = 5'd9;
  localparam logic [4:0] S_P_GO     = 5'd10;
  localparam logic [4:0] S_P_WAIT   = 5'd11;
  localparam logic [4:0] S_PR_INIT  = 5'd12;
  localparam logic [4:0] S_A_RD     = 5'd13;
  localparam logic [4:0] S_A_LAT    = 5'd14;
  localparam logic [4:0] S_B_RD     = 5'd15;
  localparam logic [4:0] S_B_LAT    = 5'd16;
  localparam logic [4:0] S_SQ1_GO   = 5'd17;
  localparam logic [4:0] S_SQ1_WAIT = 5'd18;
  localparam logic [4:0] S_SQ2_GO   = 5'd19;
  localparam logic [4:0] S_SQ2_WAIT = 5'd20;
  localparam logic [4:0] S_RT_WAIT  = 5'd21;
  localparam logic [4:0] S_DONE     = 5'd22;

  // Input word fields.
  logic                     in_kind;
  logic [5:0]               in_slot;
  logic [PT_W-1:0]          in_pt;
  logic [ETA_W-1:0]         in_eta;
  logic [PHI_W-1:0]         in_phi;
  logic [GROUP_W-1:0]       in_group;
  logic                     in_acc;

  assign in_kind  = s_axis_tuser;
  assign in_slot  = s_axis_tdata[5:0];
  assign in_pt    = s_axis_tdata[21:6];
  assign in_eta   = s_axis_tdata[37:22];
  assign in_phi   = s_axis_tdata[52:38];
  assign in_group = s_axis_tdata[82:53];

  // Configuration registers.
  logic [2:0]  point_count_q;
  logic [6:0]  particle_count_q;
  logic [2:0]  weight_power_q;
  logic [15:0] inv_scale_q;

  // Control state.
  logic [4:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Sequencer payload.
  logic [CW-1:0]      k_q, k_d, pi_q, pi_d, pj_q, pj_d, mptr_q, mptr_d;
  logic [IW-1:0]      pidx_q, pidx_d;
  logic [DCW-1:0]     dcnt_q, dcnt_d;
  logic [QW-1:0]      quo_q, quo_d;
  logic [GROUP_W-1:0] rem_q, rem_d, group_q, group_d;
  logic [PWW-1:0]     cur_q, cur_d;
  logic [63:0]        w_q, w_d, r_q, r_d;
  logic               sat_q, sat_d, first_q, first_d;
  logic [2:0]         pc_q, pc_d;
  logic [31:0]        sq1_q, sq1_d;
  logic [DIST_W-1:0]  best_d_q, best_d_d;
  logic [QW-1:0]      best_a_q, best_a_d, best_b_q, best_b_d;
  logic [QW-1:0]      slot_a_q, slot_a_d, slot_b_q, slot_b_d;
  logic [1:0]         st_q, st_d;
  logic signed [ETA_W-1:0] eta_a_q, eta_a_d, eta_b_q, eta_b_d;
  logic signed [PHI_W-1:0] phi_a_q, phi_a_d, phi_b_q, phi_b_d;
  logic [95:0]        out_data_q, out_data_d;
  logic [1:0]         out_user_q, out_user_d;

  // Member digits and powers of the particle count.
  logic [QW-1:0]  mem_q [MAX_POINTS];
  logic [PWW-1:0] pow_q [MAX_POINTS];
  logic           mem_we, pow_we;
  logic [IW-1:0]  mem_wi, pow_wi;
  logic [QW-1:0]  mem_wd;
  logic [PWW-1:0] pow_wd;
  logic [QW-1:0]  mem_rd;
  logic [PWW-1:0] pow_rd;

  assign mem_rd = mem_q[mptr_q[IW-1:0]];
  assign pow_rd = pow_q[pidx_q];

  // Effective member count and base after saturation.
  logic [CW-1:0] n_w;
  logic [6:0]    p_w;

  always_comb begin
    if (point_count_q < 3'd2) begin
      n_w = CW'(2);
    end else if (int'(point_count_q) > MAX_POINTS) begin
      n_w = CW'(MAX_POINTS);
    end else begin
      n_w = CW'(point_count_q);
    end
    if (int'(particle_count_q) > MAX_PARTICLES) begin
      p_w = 7'(MAX_PARTICLES);
    end else begin
      p_w = particle_count_q;
    end
  end

  // Particle store.
  logic              ram_we;
  logic [QW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [PT_W-1:0]   rd_pt;
  logic signed [ETA_W-1:0] rd_eta;
  logic signed [PHI_W-1:0] rd_phi;
  logic [31:0]       pt_f;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign ram_we    = in_acc && (in_kind == KIND_LOAD) && (int'(in_slot) < MAX_PARTICLES);
  assign ram_waddr = QW'(in_slot);
  assign ram_wdata = {in_phi, in_eta, in_pt};
  assign rd_pt     = ram_rdata[PT_W-1:0];
  assign rd_eta    = $signed(ram_rdata[PT_W+ETA_W-1:PT_W]);
  assign rd_phi    = $signed(ram_rdata[ENTRY_W-1:PT_W+ETA_W]);

  // Scaled pt factor in Q.20, formed at full 32-bit width.
  assign pt_f      = {16'd0, rd_pt} * {16'd0, inv_scale_q};

  ncge_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (mem_rd),
    .rdata_o (ram_rdata)
  );

  // Shared multiplier and square root unit.
  logic              mul_start, mul_done;
  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic              rt_start, rt_done;
  logic [SQ_W-1:0]   rt_val;
  logic [DIST_W-1:0] rt_root;

  ncge_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  ncge_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rt_start),
    .val_i   (rt_val),
    .done_o  (rt_done),
    .root_o  (rt_root)
  );

  // Pair differences. The azimuth difference gets a single wrap step into [-pi, pi].
  logic signed [16:0] deta_w, dphi_raw, dphi_w;
  logic [15:0]        deta_abs, dphi_abs;

  assign deta_w   = 17'(eta_a_q) - 17'(eta_b_q);
  assign dphi_raw = 17'(phi_b_q) - 17'(phi_a_q);

  always_comb begin
    if (dphi_raw > PI_Q12) begin
      dphi_w = dphi_raw - TWO_PI_Q12;
    end else if (dphi_raw < -PI_Q12) begin
      dphi_w = dphi_raw + TWO_PI_Q12;
    end else begin
      dphi_w = dphi_raw;
    end
  end

  assign deta_abs = deta_w[16] ? 16'(-deta_w) : deta_w[15:0];
  assign dphi_abs = dphi_w[16] ? 16'(-dphi_w) : dphi_w[15:0];

  // One restoring division step for the group digits.
  logic [CMPW-1:0] trial_w;
  logic            ge_w;
  logic [QW-1:0]   quo_nx;

  assign trial_w = CMPW'(pow_rd) << dcnt_q;
  assign ge_w    = CMPW'(rem_q) >= trial_w;
  assign quo_nx  = quo_q | (ge_w ? (QW'(1) << dcnt_q) : '0);

  // Result word assembled from the sequencer state.
  logic        q_done;
  logic [63:0] w_out;

  assign q_done = (st_q == ST_OK) || (st_q == ST_SAT);

  always_comb begin
    if (st_q == ST_SAT) begin
      w_out = '1;
    end else if (st_q == ST_OK) begin
      w_out = r_q;
    end else begin
      w_out = '0;
    end
  end

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    pi_d      = pi_q;
    pj_d      = pj_q;
    mptr_d    = mptr_q;
    pidx_d    = pidx_q;
    dcnt_d    = dcnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    group_d   = group_q;
    cur_d     = cur_q;
    w_d       = w_q;
    r_d       = r_q;
    sat_d     = sat_q;
    first_d   = first_q;
    pc_d      = pc_q;
    sq1_d     = sq1_q;
    best_d_d  = best_d_q;
    best_a_d  = best_a_q;
    best_b_d  = best_b_q;
    slot_a_d  = slot_a_q;
    slot_b_d  = slot_b_q;
    st_d      = st_q;
    eta_a_d   = eta_a_q;
    phi_a_d   = phi_a_q;
    eta_b_d   = eta_b_q;
    phi_b_d   = phi_b_q;
    mem_we    = 1'b0;
    mem_wi    = k_q[IW-1:0];
    mem_wd    = quo_nx;
    pow_we    = 1'b0;
    pow_wi    = '0;
    pow_wd    = mul_prod[PWW-1:0];
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    rt_start  = 1'b0;
    rt_val    = SQ_W'(sq1_q) + SQ_W'(mul_prod[31:0]);

    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_LOAD) begin
            st_d    = ST_LOAD;
            state_d = S_DONE;
          end else begin
            group_d = in_group;
            cur_d   = PWW'(1);
            k_d     = '0;
            pow_we  = 1'b1;
            pow_wi  = '0;
            pow_wd  = PWW'(1);
            state_d = S_POW_GO;
          end
        end
      end

      // Powers of the base, p^0 .. p^n; p^n bounds the group number.
      S_POW_GO: begin
        if (k_q == n_w) begin
          state_d = S_RANGE;
        end else begin
          mul_start = 1'b1;
          mul_a     = MUL_W'(cur_q);
          mul_b     = MUL_W'(p_w);
          state_d   = S_POW_WAIT;
        end
      end

      S_POW_WAIT: begin
        if (mul_done) begin
          cur_d = mul_prod[PWW-1:0];
          if (k_q + CW'(1) < n_w) begin
            pow_we = 1'b1;
            pow_wi = IW'(k_q + CW'(1));
          end
          k_d     = k_q + CW'(1);
          state_d = S_POW_GO;
        end
      end

      S_RANGE: begin
        if (CMPW'(group_q) >= CMPW'(cur_q)) begin
          st_d    = ST_OOR;
          state_d = S_DONE;
        end else begin
          rem_d   = group_q;
          k_d     = '0;
          pidx_d  = IW'(n_w - CW'(1));
          dcnt_d  = DCW'(QW - 1);
          quo_d   = '0;
          state_d = S_DIG;
        end
      end

      // Most significant digit first: digit i is rem / p^(n-1-i).
      S_DIG: begin
        quo_d = quo_nx;
        if (ge_w) begin
          rem_d = rem_q - trial_w[GROUP_W-1:0];
        end
        if (dcnt_q == '0) begin
          mem_we = 1'b1;
          if (k_q == n_w - CW'(1)) begin
            k_d     = '0;
            mptr_d  = '0;
            w_d     = ONE_Q32;
            sat_d   = 1'b0;
            state_d = S_W_RD;
          end else begin
            k_d    = k_q + CW'(1);
            pidx_d = pidx_q - IW'(1);
            dcnt_d = DCW'(QW - 1);
            quo_d  = '0;
          end
        end else begin
          dcnt_d = dcnt_q - DCW'(1);
        end
      end

      S_W_RD: begin
        state_d = S_W_GO;
      end

      S_W_GO: begin
        mul_start = 1'b1;
        mul_a     = w_q;
        mul_b     = MUL_W'(pt_f);
        state_d   = S_W_WAIT;
      end

      // Product scaled back by 2^20; anything above 64 bits saturates.
      S_W_WAIT: begin
        if (mul_done) begin
          if (mul_prod[127:84] != '0) begin
            sat_d = 1'b1;
            w_d   = '1;
          end else begin
            w_d = mul_prod[83:20];
          end
          if (k_q == n_w - CW'(1)) begin
            state_d = S_P_INIT;
          end else begin
            k_d     = k_q + CW'(1);
            mptr_d  = k_q + CW'(1);
            state_d = S_W_RD;
          end
        end
      end

      S_P_INIT: begin
        r_d     = w_q;
        pc_d    = 3'd1;
        state_d = S_P_CHK;
      end

      S_P_CHK: begin
        if (weight_power_q == 3'd0) begin
          r_d     = ONE_Q32;
          sat_d   = 1'b0;
          state_d = S_PR_INIT;
        end else if (pc_q < weight_power_q) begin
          state_d = S_P_GO;
        end else begin
          state_d = S_PR_INIT;
        end
      end

      S_P_GO: begin
        mul_start = 1'b1;
        mul_a     = r_q;
        mul_b     = w_q;
        state_d   = S_P_WAIT;
      end

      S_P_WAIT: begin
        if (mul_done) begin
          if (mul_prod[127:96] != '0) begin
            sat_d = 1'b1;
            r_d   = '1;
          end else begin
            r_d = mul_prod[95:32];
          end
          pc_d    = pc_q + 3'd1;
          state_d = S_P_CHK;
        end
      end

      S_PR_INIT: begin
        pi_d    = '0;
        pj_d    = CW'(1);
        mptr_d  = '0;
        first_d = 1'b1;
        state_d = S_A_RD;
      end

      S_A_RD: begin
        state_d = S_A_LAT;
      end

      S_A_LAT: begin
        eta_a_d  = rd_eta;
        phi_a_d  = rd_phi;
        slot_a_d = mem_rd;
        mptr_d   = pj_q;
        state_d  = S_B_RD;
      end

      S_B_RD: begin
        state_d = S_B_LAT;
      end

      S_B_LAT: begin
        eta_b_d  = rd_eta;
        phi_b_d  = rd_phi;
        slot_b_d = mem_rd;
        state_d  = S_SQ1_GO;
      end

      S_SQ1_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(dphi_abs);
        mul_b     = MUL_W'(dphi_abs);
        state_d   = S_SQ1_WAIT;
      end

      S_SQ1_WAIT: begin
        if (mul_done) begin
          sq1_d   = mul_prod[31:0];
          state_d = S_SQ2_GO;
        end
      end

      S_SQ2_GO: begin
        mul_start = 1'b1;
        mul_a     = MUL_W'(deta_abs);
        mul_b     = MUL_W'(deta_abs);
        state_d   = S_SQ2_WAIT;
      end

      S_SQ2_WAIT: begin
        if (mul_done) begin
          rt_start = 1'b1;
          state_d  = S_RT_WAIT;
        end
      end

      // The first pair always sets the best; later ones only when strictly farther.
      S_RT_WAIT: begin
        if (rt_done) begin
          first_d = 1'b0;
          if (first_q || (rt_root > best_d_q)) begin
            best_d_d = rt_root;
            best_a_d = slot_a_q;
            best_b_d = slot_b_q;
          end
          if (pj_q == n_w - CW'(1)) begin
            if (pi_q == n_w - CW'(2)) begin
              st_d    = sat_q ? ST_SAT : ST_OK;
              state_d = S_DONE;
            end else begin
              pi_d    = pi_q + CW'(1);
              pj_d    = pi_q + CW'(2);
              mptr_d  = pi_q + CW'(1);
              state_d = S_A_RD;
            end
          end else begin
            pj_d    = pj_q + CW'(1);
            mptr_d  = pi_q;
            state_d = S_A_RD;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_user_d  = st_q;
          out_data_d  = {3'd0,
                         q_done ? 6'(best_b_q) : 6'd0,
                         q_done ? 6'(best_a_q) : 6'd0,
                         q_done ? best_d_q : '0,
                         w_out};
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      out_valid_q      <= 1'b0;
      point_count_q    <= 3'd2;
      particle_count_q <= 7'd1;
      weight_power_q   <= 3'd1;
      inv_scale_q      <= 16'd4096;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_POINT_COUNT:    point_count_q    <= cfg_data_i[2:0];
          REG_PARTICLE_COUNT: particle_count_q <= cfg_data_i[6:0];
          REG_WEIGHT_POWER:   weight_power_q   <= cfg_data_i[2:0];
          REG_INV_SCALE:      inv_scale_q      <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    pi_q       <= pi_d;
    pj_q       <= pj_d;
    mptr_q     <= mptr_d;
    pidx_q     <= pidx_d;
    dcnt_q     <= dcnt_d;
    quo_q      <= quo_d;
    rem_q      <= rem_d;
    group_q    <= group_d;
    cur_q      <= cur_d;
    w_q        <= w_d;
    r_q        <= r_d;
    sat_q      <= sat_d;
    first_q    <= first_d;
    pc_q       <= pc_d;
    sq1_q      <= sq1_d;
    best_d_q   <= best_d_d;
    best_a_q   <= best_a_d;
    best_b_q   <= best_b_d;
    slot_a_q   <= slot_a_d;
    slot_b_q   <= slot_b_d;
    st_q       <= st_d;
    eta_a_q    <= eta_a_d;
    phi_a_q    <= phi_a_d;
    eta_b_q    <= eta_b_d;
    phi_b_q    <= phi_b_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    if (mem_we) begin
      mem_q[mem_wi] <= mem_wd;
    end
    if (pow_we) begin
      pow_q[pow_wi] <= pow_wd;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ----- rtl/ncge_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ncge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/ncge_mul.sv -----
// Shared 64x64 multiplier built from four 32x32 partial products over several cycles.
module ncge_mul import ncge_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [MUL_W-1:0]  a_i,
  input  logic [MUL_W-1:0]  b_i,
  output logic              done_o,
  output logic [PROD_W-1:0] prod_o
);

  logic [MUL_W-1:0]  a_q, b_q, pp_q, pp_d;
  logic [PROD_W-1:0] acc_q, pp_shifted;
  logic [1:0]        ptag_q;
  logic [2:0]        cnt_q;
  logic              busy_q, pv_q, done_q;
  logic [31:0]       a_half, b_half;

  assign a_half = cnt_q[0] ? a_q[63:32] : a_q[31:0];
  assign b_half = cnt_q[1] ? b_q[63:32] : b_q[31:0];
  assign pp_d   = a_half * b_half;

  // Weight of a partial product is 2^(32 * (number of high halves used)).
  always_comb begin
    unique case (ptag_q)
      2'b00:   pp_shifted = {64'd0, pp_q};
      2'b11:   pp_shifted = {pp_q, 64'd0};
      default: pp_shifted = {32'd0, pp_q, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      done_q <= busy_q && cnt_q[2];
      if (busy_q) begin
        if (!cnt_q[2]) begin
          pv_q  <= 1'b1;
          cnt_q <= cnt_q + 3'd1;
        end else begin
          pv_q   <= 1'b0;
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else begin
      if (pv_q) begin
        acc_q <= acc_q + pp_shifted;
      end
      if (busy_q && !cnt_q[2]) begin
        pp_q   <= pp_d;
        ptag_q <= cnt_q[1:0];
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/ncge_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
module ncge_sqrt import ncge_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   val_i,
  output logic              done_o,
  output logic [DIST_W-1:0] root_o
);

  logic [SQ_W-1:0] v_q, bit_q;
  logic [SQ_W:0]   r_q, sum_w, r_nx;
  logic            busy_q, done_q, ge_w;

  assign sum_w = r_q + (SQ_W + 1)'(bit_q);
  assign ge_w  = (SQ_W + 1)'(v_q) >= sum_w;
  assign r_nx  = ge_w ? ((r_q >> 1) + (SQ_W + 1)'(bit_q)) : (r_q >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= SQ_W'(1) << (SQ_W - 2);
    end else if (busy_q) begin
      if (ge_w) begin
        v_q <= v_q - sum_w[SQ_W-1:0];
      end
      r_q   <= r_nx;
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[DIST_W-1:0];

endmodule

// ----- tb/sv/npoint_correlator_group_eval_tb.sv -----
// Testbench of the n-point correlator group evaluator: directed table, random stream, predictor.
`timescale 1ns / 100ps

module npoint_correlator_group_eval_tb import ncge_pkg::*;;

  localparam int NSLOT = 64;
  localparam int NPTS  = 5;
  localparam int LIMIT = 3_000_000;

  // One input word as the block sees it.
  typedef struct packed {
    logic        kind;
    logic [5:0]  slot;
    logic [15:0] pt;
    logic [15:0] eta;
    logic [14:0] phi;
    logic [29:0] group;
  } req_t;

  // One result word.
  typedef struct packed {
    logic [63:0] weight;
    logic [16:0] distance;
    logic [5:0]  first_member;
    logic [5:0]  second_member;
    logic [1:0]  status;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  npoint_correlator_group_eval dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of the particle store and the registers.
  logic [15:0]        pt_mem  [NSLOT];
  logic signed [15:0] eta_mem [NSLOT];
  logic signed [14:0] phi_mem [NSLOT];
  int unsigned        npts_reg, nparts_reg, power_reg, scale_reg;

  res_t   pending_results[$];
  int     mismatches = 0;
  longint cycles = 0;
  bit     quiet_rx = 0;   // receiver never stalls
  bit     hold_rx  = 0;   // receiver blocked for a long stretch
  bit     quiet_tx = 0;

  task automatic report(input string what, input logic [95:0] got, input logic [95:0] want);
    $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // floor(a*b/2^s), flagging any result beyond 64 bits.
  function automatic logic [63:0] scaled_mul(input logic [63:0] a, input logic [63:0] b,
                                             input int s, inout bit sat);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    if (p[127:64] != 0) begin
      sat = 1;
      return '1;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] spread(input int a, input int b);
    longint dp, de;
    dp = longint'(phi_mem[b]) - longint'(phi_mem[a]);
    de = longint'(eta_mem[a]) - longint'(eta_mem[b]);
    if (dp > 12868) dp -= 25736;
    else if (dp < -12868) dp += 25736;
    return isqrt(64'(dp * dp + de * de));
  endfunction

  // Work out the result of one word, updating the store on loads.
  function automatic res_t correlate(input req_t q);
    res_t o;
    int unsigned n, p, m[NPTS], ba, bb;
    longint unsigned total, rem;
    logic [63:0] bd, d, w, r;
    bit sat;
    o = '0;
    sat = 0;
    if (q.kind == KIND_LOAD) begin
      pt_mem[q.slot] = q.pt;
      eta_mem[q.slot] = q.eta;
      phi_mem[q.slot] = q.phi;
      o.status = ST_LOAD;
      return o;
    end
    n = npts_reg < 2 ? 2 : (npts_reg > NPTS ? NPTS : npts_reg);
    p = nparts_reg > NSLOT ? NSLOT : nparts_reg;
    total = 1;
    for (int i = 0; i < n; i++) total *= p;
    rem = 64'(q.group);
    if (rem >= total) begin
      o.status = ST_OOR;
      return o;
    end
    for (int i = n - 1; i >= 0; i--) begin
      m[i] = 32'(rem % p);
      rem /= p;
    end
    ba = m[0];
    bb = m[1];
    bd = spread(ba, bb);
    for (int i = 0; i < n - 1; i++)
      for (int j = i + 1; j < n; j++) begin
        d = spread(m[i], m[j]);
        if (d > bd) begin
          bd = d;
          ba = m[i];
          bb = m[j];
        end
      end
    w = ONE_Q32;
    for (int i = 0; i < n; i++) w = scaled_mul(w, 64'(pt_mem[m[i]]) * scale_reg, 20, sat);
    if (power_reg == 0) begin
      r = ONE_Q32;
      sat = 0;
    end else begin
      r = w;
      for (int i = 1; i < power_reg; i++) r = scaled_mul(r, w, 32, sat);
    end
    o.weight = sat ? '1 : r;
    o.distance = bd[16:0];
    o.first_member = ba[5:0];
    o.second_member = bb[5:0];
    o.status = sat ? ST_SAT : ST_OK;
    return o;
  endfunction

  function automatic logic [95:0] pack_res(input res_t o);
    return {3'b0, o.second_member, o.first_member, o.distance, o.weight};
  endfunction

  // Offer one word with random gaps, predict once it is taken. The word stays on the
  // bus after the accepting edge until the next word or stop_tx replaces it; the
  // block is busy meanwhile and cannot take it twice.
  task automatic send(input req_t q, input bit typed, input res_t want);
    res_t e;
    @(negedge clk_i);
    if (!quiet_tx) begin
      while ($urandom_range(99) < 24) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.kind;
    s_axis_tdata  <= {5'b0, q.group, q.phi, q.eta, q.pt, q.slot};
    do @(posedge clk_i); while (!s_axis_tready);
    e = correlate(q);
    if (typed && e != want) report("table row", pack_res(want), pack_res(e));
    pending_results = {pending_results, e};
  endtask

  task automatic stop_tx();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    stop_tx();
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_POINT_COUNT:    npts_reg = val[2:0];
      REG_PARTICLE_COUNT: nparts_reg = val[6:0];
      REG_WEIGHT_POWER:   power_reg = val[2:0];
      REG_INV_SCALE:      scale_reg = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t load_word(input int s);
    req_t q;
    q = req_t'(84'({$urandom, $urandom, $urandom}));
    q.kind = KIND_LOAD;
    q.slot = 6'(s);
    q.phi = 15'($signed($urandom_range(25736)) - 12868);
    return q;
  endfunction

  // Query inside the loaded range, sometimes beyond it.
  function automatic req_t query_word();
    req_t q;
    longint unsigned total;
    int n;
    q = '0;
    q.kind = KIND_QUERY;
    q.slot = 6'($urandom);
    q.pt = 16'($urandom);
    n = npts_reg < 2 ? 2 : (npts_reg > NPTS ? NPTS : npts_reg);
    total = 1;
    for (int i = 0; i < n; i++) total *= (nparts_reg > NSLOT ? NSLOT : nparts_reg);
    if ($urandom_range(9) == 0 || total == 0) q.group = 30'($urandom);
    else if (total > 30'h3FFF_FFFF) q.group = 30'($urandom);
    else q.group = 30'($urandom % total);
    return q;
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    res_t e;
    logic [95:0] w;
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", m_axis_tdata, '0);
      end else begin
        e = pending_results.pop_front();
        w = pack_res(e);
        if (m_axis_tdata[63:0] != w[63:0]) report("weight", m_axis_tdata, w);
        if (m_axis_tdata[80:64] != w[80:64]) report("distance", m_axis_tdata, w);
        if (m_axis_tdata[86:81] != w[86:81]) report("first_member", m_axis_tdata, w);
        if (m_axis_tdata[92:87] != w[92:87]) report("second_member", m_axis_tdata, w);
        if (m_axis_tuser != e.status) report("status", {94'd0, m_axis_tuser}, {94'd0, e.status});
      end
    end
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request, a quiet stretch.
  always @(negedge clk_i) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else if (quiet_rx) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(99) >= 24);
  end

  initial begin
    req_t  q;
    res_t  z;
    req_t  rows[$];
    res_t  wants[$];
    bit    typed[$];
    int    nslots;
    int    pc[4], sc[4];
    npts_reg = 2;
    nparts_reg = 1;
    power_reg = 1;
    scale_reg = 4096;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. Loads report zeros with a load status.
    z = '0;
    q = '0;
    q.kind = KIND_LOAD;
    q.pt = 16'h0100; q.eta = 16'h7FFF; q.phi = 15'sd12868; q.slot = 0;
    rows = {rows, q}; wants = {wants, z}; typed = {typed, 1'b1};
    q.slot = 63; q.pt = 16'hFFFF; q.eta = 16'h8000; q.phi = -15'sd12868;
    rows = {rows, q}; wants = {wants, z}; typed = {typed, 1'b1};
    q.slot = 1; q.pt = 16'h0000; q.eta = 16'h0000; q.phi = 15'sd0;
    rows = {rows, q}; wants = {wants, z}; typed = {typed, 1'b1};
    // Single particle, group 0 of base 1: pair (0,0) with pt 1.0, unit scale.
    q = '0;
    q.kind = KIND_QUERY;
    z.weight = ONE_Q32; z.status = ST_OK;
    rows = {rows, q}; wants = {wants, z}; typed = {typed, 1'b1};
    // Group out of range.
    z = '0; z.status = ST_OOR;
    q.group = 1; rows = {rows, q}; wants = {wants, z}; typed = {typed, 1'b1};
    q.group = 30'h3FFF_FFFF; rows = {rows, q}; wants = {wants, z}; typed = {typed, 1'b1};
    foreach (rows[i]) send(rows[i], typed[i], wants[i]);

    // Fill every slot, then sweep settings including extremes and odd values.
    for (int s = 0; s < NSLOT; s++) send(load_word(s), 0, z);
    write_reg(REG_PARTICLE_COUNT, 16'd64);
    write_reg(REG_POINT_COUNT, 16'd5);
    write_reg(REG_WEIGHT_POWER, 16'd0);
    write_reg(REG_INV_SCALE, 16'hFFFF);
    q = '0; q.kind = KIND_QUERY; q.group = 30'h3FFF_FFFF;
    send(q, 0, z);
    q.group = 30'(64 * 64 * 64 * 64 - 1);
    send(q, 0, z);

    // Pressure: receiver holds off while words keep coming.
    write_reg(REG_POINT_COUNT, 16'd2);
    write_reg(REG_WEIGHT_POWER, 16'd7);
    hold_rx = 1;
    fork
      begin
        repeat (400) @(negedge clk_i);
        hold_rx = 0;
      end
      for (int i = 0; i < 8; i++) send(query_word(), 0, z);
    join

    pc = '{2, 3, 5, 7};
    sc = '{0, 16'd4096, 16'd300, 16'hFFFF};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_POINT_COUNT, 16'(ph == 7 ? 0 : pc[ph % 4]));
      nslots = ph == 5 ? 0 : (ph == 6 ? 127 : (ph % 3 == 0 ? 64 : $urandom_range(1, 8)));
      write_reg(REG_PARTICLE_COUNT, 16'(nslots));
      write_reg(REG_WEIGHT_POWER, 16'($urandom_range(0, 7)));
      write_reg(REG_INV_SCALE, 16'(ph == 4 ? $urandom : sc[ph % 4]));
      quiet_rx = (ph == 2);
      quiet_tx = (ph == 2);
      for (int k = 0; k < 85; k++) begin
        if ($urandom_range(3) == 0) send(load_word($urandom_range(63)), 0, z);
        else send(query_word(), 0, z);
      end
    end
    stop_tx();
    quiet_rx = 0;
    quiet_tx = 0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ncge_pkg.sv
rtl/ncge_ram.sv
rtl/ncge_mul.sv
rtl/ncge_sqrt.sv
rtl/npoint_correlator_group_eval.sv
tb/sv/npoint_correlator_group_eval_tb.sv
